### sv/pfg_pkg.sv
// Shared types, constants and helpers for the playfield pixel generator.
`timescale 1ns / 1ps

package pfg_pkg;

    localparam int LINE_PIXELS  = 160;
    localparam int HALF_X       = LINE_PIXELS / 2;
    localparam int HALF_COLS    = LINE_PIXELS / 8;
    localparam int PATTERN_BITS = 20;

    localparam logic [7:0] COLOUR_MASK = 8'hFE;

    localparam int TDATA_IN_W  = 16;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 32;
    localparam int MASK_W      = 16;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_PF0       = 3'd1,
        REQ_PF1       = 3'd2,
        REQ_PF2       = 3'd3,
        REQ_CTRL      = 3'd4,
        REQ_PF_COLOUR = 3'd5,
        REQ_P0_COLOUR = 3'd6,
        REQ_P1_COLOUR = 3'd7
    } req_type_t;

    typedef enum logic {
        CFG_MASK_OFF = 1'b0,
        CFG_MASK_ON  = 1'b1
    } cfg_index_t;

    // Playfield result after one beat, before the collision word is chosen.
    typedef struct packed {
        logic       pixel_on;
        logic [7:0] colour;
    } pix_result_t;

    // PF1 is displayed with its bits in reverse order.
    function automatic logic [7:0] pf1_reverse(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

### sv/pfg_state.sv
// Playfield state registers and the next-result logic for one beat.
`timescale 1ns / 1ps

module pfg_state (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  pfg_pkg::req_type_t   req_type,
    input  logic [7:0]           pixel_x,
    input  logic [7:0]           write_data,
    output pfg_pkg::pix_result_t result
);

    logic [pfg_pkg::PATTERN_BITS-1:0] pattern_reg, pattern_next;
    logic       reflect_request_reg, reflect_request_next;
    logic       reflect_latched_reg, reflect_latched_next;
    logic       score_mode_reg, score_mode_next;
    logic [7:0] field_colour_reg, field_colour_next;
    logic [7:0] player0_colour_reg, player0_colour_next;
    logic [7:0] player1_colour_reg, player1_colour_next;
    logic [7:0] last_x_reg, last_x_next;
    logic       held_pixel_reg, held_pixel_next;

    logic [5:0] col;
    logic [4:0] idx;
    logic       have;

    assign col = pixel_x[7:2];

    // Pattern bit for this column: the right half repeats or mirrors the left.
    always_comb
    begin
        have = 1'b1;
        idx  = '0;
        if (col < 6'(pfg_pkg::HALF_COLS))
        begin
            idx = col[4:0];
        end
        else if (col < 6'(2 * pfg_pkg::HALF_COLS))
        begin
            if (reflect_latched_next)
                idx = 5'(6'(2 * pfg_pkg::HALF_COLS - 1) - col);
            else
                idx = 5'(col - 6'(pfg_pkg::HALF_COLS));
        end
        else
        begin
            have = 1'b0;
        end
    end

    always_comb
    begin
        pattern_next         = pattern_reg;
        reflect_request_next = reflect_request_reg;
        reflect_latched_next = reflect_latched_reg;
        score_mode_next      = score_mode_reg;
        field_colour_next    = field_colour_reg;
        player0_colour_next  = player0_colour_reg;
        player1_colour_next  = player1_colour_reg;
        last_x_next          = last_x_reg;
        held_pixel_next      = held_pixel_reg;
        case (req_type)
            pfg_pkg::REQ_TICK:
            begin
                last_x_next = pixel_x;
                if (pixel_x == 8'd0 || pixel_x == 8'(pfg_pkg::HALF_X))
                    reflect_latched_next = reflect_request_reg;
            end
            pfg_pkg::REQ_PF0:
                pattern_next = {pattern_reg[19:4], write_data[7:4]};
            pfg_pkg::REQ_PF1:
                pattern_next = {pattern_reg[19:12], pfg_pkg::pf1_reverse(write_data),
                                pattern_reg[3:0]};
            pfg_pkg::REQ_PF2:
                pattern_next = {write_data, pattern_reg[11:0]};
            pfg_pkg::REQ_CTRL:
            begin
                reflect_request_next = write_data[0];
                score_mode_next      = (write_data[2:1] == 2'b01);
            end
            pfg_pkg::REQ_PF_COLOUR:
                field_colour_next = write_data & pfg_pkg::COLOUR_MASK;
            pfg_pkg::REQ_P0_COLOUR:
                player0_colour_next = write_data & pfg_pkg::COLOUR_MASK;
            pfg_pkg::REQ_P1_COLOUR:
                player1_colour_next = write_data & pfg_pkg::COLOUR_MASK;
            default:
                pattern_next = pattern_reg;
        endcase
        // The held pixel is only resampled on ticks at a multiple of four.
        if (req_type == pfg_pkg::REQ_TICK && pixel_x[1:0] == 2'b00)
            held_pixel_next = have && pattern_reg[idx];
    end

    always_comb
    begin
        result.pixel_on = held_pixel_next;
        if (score_mode_next)
            result.colour = (last_x_next < 8'(pfg_pkg::HALF_X)) ? player0_colour_next
                                                                 : player1_colour_next;
        else
            result.colour = field_colour_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg         <= '0;
            reflect_request_reg <= 1'b0;
            reflect_latched_reg <= 1'b0;
            score_mode_reg      <= 1'b0;
            field_colour_reg    <= '0;
            player0_colour_reg  <= '0;
            player1_colour_reg  <= '0;
            last_x_reg          <= '0;
            held_pixel_reg      <= 1'b0;
        end
        else if (accept)
        begin
            pattern_reg         <= pattern_next;
            reflect_request_reg <= reflect_request_next;
            reflect_latched_reg <= reflect_latched_next;
            score_mode_reg      <= score_mode_next;
            field_colour_reg    <= field_colour_next;
            player0_colour_reg  <= player0_colour_next;
            player1_colour_reg  <= player1_colour_next;
            last_x_reg          <= last_x_next;
            held_pixel_reg      <= held_pixel_next;
        end
    end

endmodule

### sv/playfield_pixel_generator.sv
// Top level of the playfield pixel generator: stream ports, mask registers, output stage.
// Output: an accepted beat's result is registered in the output register, or in the
// one-entry skid stage if the output is stalled. Throughput: one beat per cycle while
// the output is not stalled; s_axis_tready drops only once the skid entry is full.
// Reset: all playfield state and colours clear to zero, the off mask to 0x0000 and the
// on mask to 0xFFFF; no result is pending after reset.
`timescale 1ns / 1ps

module playfield_pixel_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [pfg_pkg::MASK_W-1:0]      cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] pixel_x, [15:8] write_data
    input  logic [pfg_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // [2:0] req_type
    input  logic [pfg_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] pixel_on, [16:1] collision_mask, [24:17] colour, [31:25] zero
    output logic [pfg_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

    localparam int RES_W = 1 + pfg_pkg::MASK_W + 8;

    logic [pfg_pkg::MASK_W-1:0] mask_off_reg;
    logic [pfg_pkg::MASK_W-1:0] mask_on_reg;

    logic                 in_fire;
    logic                 out_fire;
    pfg_pkg::pix_result_t pix;
    logic [RES_W-1:0]     res_word;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [RES_W-1:0] out_data_reg, out_data_next;
    logic [RES_W-1:0] skid_data_reg, skid_data_next;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;

    pfg_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_fire),
        .req_type   (pfg_pkg::req_type_t'(s_axis_tuser[2:0])),
        .pixel_x    (s_axis_tdata[7:0]),
        .write_data (s_axis_tdata[15:8]),
        .result     (pix)
    );

    assign res_word = {pix.colour, (pix.pixel_on ? mask_on_reg : mask_off_reg), pix.pixel_on};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_off_reg <= '0;
            mask_on_reg  <= '1;
        end
        else if (cfg_we)
        begin
            case (pfg_pkg::cfg_index_t'(cfg_addr))
                pfg_pkg::CFG_MASK_OFF: mask_off_reg <= cfg_wdata;
                pfg_pkg::CFG_MASK_ON:  mask_on_reg  <= cfg_wdata;
                default:               mask_off_reg <= mask_off_reg;
            endcase
        end
    end

    // The skid entry only fills when a beat arrives while the output is stalled.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_data_next = res_word;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg)
            begin
                skid_data_next  = res_word;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = res_word;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(pfg_pkg::TDATA_OUT_W - RES_W){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output beat");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("beat accepted during a stall was not kept in the skid entry");

    a_colour_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[17])
        else $error("colour output has bit 0 set");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the playfield pixel generator with its own predictor.
`timescale 1ns / 1ps

module testbench;

    import pfg_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 6;
    localparam int BEATS_PER_PHASE = 300;
    localparam int PRINT_CAP       = 100;

    typedef struct {
        req_type_t  kind;
        logic [7:0] x;
        logic [7:0] data;
    } pf_beat_t;

    typedef struct {
        logic        pixel_on;
        logic [15:0] collision_mask;
        logic [7:0]  colour;
    } pixel_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = CFG_MASK_OFF;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = REQ_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Predictor state.
    logic [19:0] pf_bits;
    logic        refl_req;
    logic        refl_held;
    logic        score_on;
    logic [7:0]  pf_col;
    logic [7:0]  p0_col;
    logic [7:0]  p1_col;
    logic [7:0]  tick_x;
    logic        pix_held;
    logic [15:0] mask_off_copy;
    logic [15:0] mask_on_copy;

    pf_beat_t   pending_beats[$];
    pixel_out_t expected_pixels[$];
    pf_beat_t   cur_beat;
    pixel_out_t head_pixel;

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycles = 0;
    bit  beat_taken = 1'b0;
    int  burst_left = 1;
    int  gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int  stall_reload = 0;

    int          phase;
    int          queued;
    int          sel;
    int          run_len;
    int          k;
    logic [7:0]  run_x;
    logic [15:0] new_off;
    logic [15:0] new_on;

    playfield_pixel_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic queue_beat(input req_type_t kind, input logic [7:0] x,
                              input logic [7:0] data);
        pf_beat_t b;
        b.kind = kind;
        b.x    = x;
        b.data = data;
        pending_beats.push_back(b);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] result %0d, %s: got %h, want %h", $time, results_seen, what,
                     got, want);
        mismatches++;
    endtask

    // Advances the playfield state by one accepted beat and queues the result it gives.
    task automatic predict_pixel(input req_type_t kind, input logic [7:0] x,
                                 input logic [7:0] d);
        int col;
        pixel_out_t want;
        case (kind)
            REQ_TICK:
            begin
                tick_x = x;
                if (x == 8'd0 || x == 8'(HALF_X))
                    refl_held = refl_req;
                if (x[1:0] == 2'b00)
                begin
                    col = int'(x[7:2]);
                    if (col < HALF_COLS)
                        pix_held = pf_bits[col];
                    else if (col < 2 * HALF_COLS)
                        pix_held = refl_held ? pf_bits[2 * HALF_COLS - 1 - col]
                                             : pf_bits[col - HALF_COLS];
                    else
                        pix_held = 1'b0;
                end
            end
            REQ_PF0:
                pf_bits[3:0] = d[7:4];
            REQ_PF1:
            begin
                // This register is shown with its bit order reversed.
                for (int i = 0; i < 8; i++)
                begin
                    pf_bits[11 - i] = d[i];
                end
            end
            REQ_PF2:
                pf_bits[19:12] = d;
            REQ_CTRL:
            begin
                refl_req = d[0];
                score_on = (d[2:1] == 2'b01);
            end
            REQ_PF_COLOUR:
                pf_col = d & COLOUR_MASK;
            REQ_P0_COLOUR:
                p0_col = d & COLOUR_MASK;
            default:
                p1_col = d & COLOUR_MASK;
        endcase
        want.pixel_on       = pix_held;
        want.collision_mask = pix_held ? mask_on_copy : mask_off_copy;
        if (score_on)
            want.colour = (tick_x < 8'(HALF_X)) ? p0_col : p1_col;
        else
            want.colour = pf_col;
        expected_pixels.push_back(want);
    endtask

    task automatic wait_until_drained;
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Sender: bursts of beats separated by gaps of random length.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                cur_beat = pending_beats.pop_front();
                s_axis_tdata  <= {cur_beat.data, cur_beat.x};
                s_axis_tuser  <= cur_beat.kind;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left = burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: a rotating ready pattern that is reloaded now and then.
    always @(negedge clk)
    begin
        if (stall_reload == 0)
        begin
            stall_reload = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom) | 16'h0001;
                2: stall_pattern = 16'h1111;
                default: stall_pattern = 16'h0001;
            endcase
        end
        else
        begin
            stall_reload  = stall_reload - 1;
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
        m_axis_tready <= rst_n && stall_pattern[0];
    end

    // Records accepted input beats and checks every result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                beat_taken = 1'b1;
                predict_pixel(req_type_t'(s_axis_tuser), s_axis_tdata[7:0],
                              s_axis_tdata[15:8]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("beat with nothing expected", m_axis_tdata, '0);
                else
                begin
                    head_pixel = expected_pixels.pop_front();
                    if (m_axis_tdata[0] !== head_pixel.pixel_on)
                        report_mismatch("pixel_on", 32'(m_axis_tdata[0]),
                                        32'(head_pixel.pixel_on));
                    if (m_axis_tdata[16:1] !== head_pixel.collision_mask)
                        report_mismatch("collision_mask", 32'(m_axis_tdata[16:1]),
                                        32'(head_pixel.collision_mask));
                    if (m_axis_tdata[24:17] !== head_pixel.colour)
                        report_mismatch("colour", 32'(m_axis_tdata[24:17]),
                                        32'(head_pixel.colour));
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("playfield_pixel_generator: mismatch");
            $finish;
        end
    end

    initial
    begin
        pf_bits       = '0;
        refl_req      = 1'b0;
        refl_held     = 1'b0;
        score_on      = 1'b0;
        pf_col        = '0;
        p0_col        = '0;
        p1_col        = '0;
        tick_x        = '0;
        pix_held      = 1'b0;
        mask_off_copy = 16'h0000;
        mask_on_copy  = 16'hFFFF;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening: reflected and repeated halves, held pixels, the edge of the line.
        queue_beat(REQ_TICK, 8'd0, 8'hFF);
        queue_beat(REQ_PF0, 8'hFF, 8'hFF);
        queue_beat(REQ_PF1, 8'h00, 8'h01);
        queue_beat(REQ_PF2, 8'h5A, 8'h80);
        queue_beat(REQ_CTRL, 8'h00, 8'h01);
        queue_beat(REQ_PF_COLOUR, 8'h00, 8'hFF);
        queue_beat(REQ_TICK, 8'd0, 8'h00);
        queue_beat(REQ_TICK, 8'd2, 8'h00);
        queue_beat(REQ_TICK, 8'd44, 8'h00);
        queue_beat(REQ_TICK, 8'd76, 8'h00);
        queue_beat(REQ_TICK, 8'd79, 8'h00);
        queue_beat(REQ_TICK, 8'd80, 8'h00);
        queue_beat(REQ_TICK, 8'd156, 8'h00);
        queue_beat(REQ_TICK, 8'd159, 8'h00);
        queue_beat(REQ_TICK, 8'd160, 8'h00);
        queue_beat(REQ_TICK, 8'd255, 8'h00);
        queue_beat(REQ_CTRL, 8'h00, 8'hFE);
        queue_beat(REQ_CTRL, 8'h00, 8'h02);
        queue_beat(REQ_P0_COLOUR, 8'h00, 8'hFF);
        queue_beat(REQ_P1_COLOUR, 8'hFF, 8'h01);
        queue_beat(REQ_TICK, 8'd252, 8'h00);
        queue_beat(REQ_TICK, 8'd4, 8'h00);
        queue_beat(REQ_PF1, 8'h00, 8'hFE);
        queue_beat(REQ_CTRL, 8'h00, 8'h00);
        queue_beat(REQ_TICK, 8'd80, 8'h00);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                // The mask registers are only touched with nothing in flight.
                wait_until_drained();
                case (phase)
                    1: begin new_off = 16'hFFFF; new_on = 16'h0000; end
                    2: begin new_off = 16'h0000; new_on = 16'h0000; end
                    3: begin new_off = 16'hFFFF; new_on = 16'hFFFF; end
                    4: begin new_off = 16'h0000; new_on = 16'hFFFF; end
                    default: begin new_off = 16'($urandom); new_on = 16'($urandom); end
                endcase
                cfg_we    <= 1'b1;
                cfg_addr  <= CFG_MASK_OFF;
                cfg_wdata <= new_off;
                @(negedge clk);
                cfg_addr  <= CFG_MASK_ON;
                cfg_wdata <= new_on;
                @(negedge clk);
                cfg_we <= 1'b0;
                mask_off_copy = new_off;
                mask_on_copy  = new_on;
            end

            queued = 0;
            while (queued < BEATS_PER_PHASE)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                begin
                    // A stretch of consecutive ticks with the odd register write mixed in.
                    run_x   = 8'($urandom_range(0, 39) * 4);
                    run_len = $urandom_range(4, 48);
                    for (k = 0; k < run_len; k++)
                    begin
                        if ($urandom_range(0, 15) == 0)
                        begin
                            queue_beat(req_type_t'($urandom_range(1, 7)), 8'($urandom),
                                       8'($urandom));
                            queued++;
                        end
                        queue_beat(REQ_TICK, run_x, 8'($urandom));
                        queued++;
                        run_x = (run_x == 8'(LINE_PIXELS - 1)) ? 8'd0 : run_x + 8'd1;
                    end
                end
                else if (sel < 8)
                begin
                    run_len = $urandom_range(1, 4);
                    for (k = 0; k < run_len; k++)
                    begin
                        queue_beat(req_type_t'($urandom_range(1, 7)), 8'($urandom),
                                   8'($urandom));
                        queued++;
                    end
                end
                else if (sel == 8)
                begin
                    // Ticks anywhere in the byte range, past the end of the line included.
                    run_len = $urandom_range(1, 6);
                    for (k = 0; k < run_len; k++)
                    begin
                        queue_beat(REQ_TICK, 8'($urandom), 8'($urandom));
                        queued++;
                    end
                end
                else
                begin
                    // Fresh pattern and control, then a line from its start.
                    queue_beat(REQ_PF0, 8'($urandom), 8'($urandom));
                    queue_beat(REQ_PF1, 8'($urandom), 8'($urandom));
                    queue_beat(REQ_PF2, 8'($urandom), 8'($urandom));
                    queue_beat(REQ_CTRL, 8'($urandom), 8'($urandom_range(0, 7)));
                    queued += 4;
                    run_len = $urandom_range(8, LINE_PIXELS);
                    for (k = 0; k < run_len; k++)
                    begin
                        queue_beat(REQ_TICK, 8'(k), 8'($urandom));
                        queued++;
                    end
                end
            end
        end

        wait_until_drained();
        if (mismatches == 0)
            $display("playfield_pixel_generator: match");
        else
            $display("playfield_pixel_generator: mismatch");
        $finish;
    end

endmodule
